FILE: src/etpq_pkg.sv
// Shared types and constants for the event time priority queue.
// Used by etpq_cell and event_time_priority_queue_core.
`default_nettype none
package etpq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TYPE_BITS_DEF    = 5;
  localparam int CONTEXT_BITS_DEF = 16;
  localparam int TIME_BITS        = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef struct packed {
    logic en;
    op_t  op;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/etpq_cell.sv
// One slot of the sorted event chain: holds an entry, compares it to the
// pushed or cancel key, and shifts to or from its neighbors. Uses etpq_pkg.
`default_nettype none
module etpq_cell import etpq_pkg::*; #(
  parameter int TYPE_BITS    = TYPE_BITS_DEF,
  parameter int CONTEXT_BITS = CONTEXT_BITS_DEF,
  parameter bit IS_HEAD      = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic [TYPE_BITS-1:0]    key_type,
  input  wire logic [CONTEXT_BITS-1:0] key_ctx,
  input  wire logic [TIME_BITS-1:0]    key_due,
  input  wire logic                    left_valid,
  input  wire logic [TYPE_BITS-1:0]    left_type,
  input  wire logic [CONTEXT_BITS-1:0] left_ctx,
  input  wire logic [TIME_BITS-1:0]    left_due,
  input  wire logic                    right_valid,
  input  wire logic [TYPE_BITS-1:0]    right_type,
  input  wire logic [CONTEXT_BITS-1:0] right_ctx,
  input  wire logic [TIME_BITS-1:0]    right_due,
  input  wire logic                    hit_in,
  output logic                         hit_out,
  output logic                         valid,
  output logic [TYPE_BITS-1:0]         ev_type,
  output logic [CONTEXT_BITS-1:0]      ev_ctx,
  output logic [TIME_BITS-1:0]         ev_due
);

  logic                    valid_r, valid_nxt;
  logic [TYPE_BITS-1:0]    type_r, type_nxt;
  logic [CONTEXT_BITS-1:0] ctx_r, ctx_nxt;
  logic [TIME_BITS-1:0]    due_r, due_nxt;
  logic [TIME_BITS-1:0]    diff;
  logic                    stop;
  logic                    flag;

  always_comb begin
    if (IS_HEAD) begin
      // head: new goes first when head due is strictly later
      diff = due_r - key_due;
      stop = (diff != '0) && !diff[TIME_BITS-1];
    end else begin
      diff = key_due - due_r;
      stop = diff[TIME_BITS-1];
    end
  end

  always_comb begin
    unique case (ctrl.op)
      OP_PUSH:   flag = valid_r ? stop : 1'b1;
      OP_CANCEL: flag = valid_r && (type_r == key_type) && (ctx_r == key_ctx);
      default:   flag = 1'b0;
    endcase
  end

  assign hit_out = hit_in | flag;

  always_comb begin
    valid_nxt = valid_r;
    type_nxt  = type_r;
    ctx_nxt   = ctx_r;
    due_nxt   = due_r;
    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_PUSH: begin
          if (hit_in) begin
            valid_nxt = left_valid;
            type_nxt  = left_type;
            ctx_nxt   = left_ctx;
            due_nxt   = left_due;
          end else if (flag) begin
            valid_nxt = 1'b1;
            type_nxt  = key_type;
            ctx_nxt   = key_ctx;
            due_nxt   = key_due;
          end
        end
        OP_POP, OP_CANCEL: begin
          if (ctrl.op == OP_POP || hit_out) begin
            valid_nxt = right_valid;
            type_nxt  = right_type;
            ctx_nxt   = right_ctx;
            due_nxt   = right_due;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    type_r <= type_nxt;
    ctx_r  <= ctx_nxt;
    due_r  <= due_nxt;
  end

  assign valid   = valid_r;
  assign ev_type = type_r;
  assign ev_ctx  = ctx_r;
  assign ev_due  = due_r;

endmodule
`default_nettype wire

FILE: src/event_time_priority_queue_core.sv
// Event queue ordered by due time, built as a chain of etpq_cell slots.
// Depends on etpq_pkg and etpq_cell.
//
// Usage:
//   Command channel: drive in_* and raise start; the command transfers at a
//   rising edge where start is high and busy is low. Operations are push,
//   pop earliest, cancel first matching type and tag, and advance time.
//   Result channel: out_valid strobes for one cycle with all out_* fields.
//   The receiver cannot stall; every result is taken in its strobe cycle.
// Timing:
//   Transfer edge, then the execute state (ST_EXEC, busy high), in which every
//   cell compares its entry to the key and shifts in parallel, then the result
//   strobe cycle. A new command may transfer during the strobe cycle, but not
//   while a command is in the execute state.
// Reset:
//   rst_n low clears the running time and all slot valid bits; the queue is
//   empty and idle afterwards. A push to a full queue sets out_push_dropped
//   and leaves the queue unchanged.
`default_nettype none
module event_time_priority_queue_core import etpq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TYPE_BITS    = TYPE_BITS_DEF,
  parameter int CONTEXT_BITS = CONTEXT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_operation,
  input  wire logic [TYPE_BITS-1:0]    in_event_type,
  input  wire logic [CONTEXT_BITS-1:0] in_context_tag,
  input  wire logic [TIME_BITS-1:0]    in_delay,
  input  wire logic [TIME_BITS-1:0]    in_elapsed,
  output logic                         out_valid,
  output logic                         out_popped_valid,
  output logic [TYPE_BITS-1:0]         out_popped_type,
  output logic [CONTEXT_BITS-1:0]      out_popped_context,
  output logic [TIME_BITS-1:0]         out_popped_due_time,
  output logic                         out_cancel_found,
  output logic                         out_push_dropped,
  output logic                         out_queue_empty,
  output logic [TIME_BITS-1:0]         out_next_due_time,
  output logic [TIME_BITS-1:0]         out_now_time
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [TYPE_BITS-1:0]    key_type_r;
  logic [CONTEXT_BITS-1:0] key_ctx_r;
  logic [TIME_BITS-1:0]    key_due_r;
  logic [TIME_BITS-1:0]    elapsed_r;
  logic [TIME_BITS-1:0]    now_r;
  logic                    out_valid_r;
  logic                    pop_valid_r;
  logic [TYPE_BITS-1:0]    pop_type_r;
  logic [CONTEXT_BITS-1:0] pop_ctx_r;
  logic [TIME_BITS-1:0]    pop_due_r;
  logic                    cancel_found_r;
  logic                    dropped_r;

  logic                    accept;
  logic                    full;
  cell_ctrl_t              ctrl;

  logic                    c_valid [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0]    c_type  [QUEUE_DEPTH];
  logic [CONTEXT_BITS-1:0] c_ctx   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]    c_due   [QUEUE_DEPTH];
  logic                    hit     [QUEUE_DEPTH+1];

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_EXEC);
  assign full   = c_valid[QUEUE_DEPTH-1];

  assign ctrl.op = op_r;
  assign ctrl.en = (state_r == ST_EXEC) && !((op_r == OP_PUSH) && full);
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                    lv, rv;
    logic [TYPE_BITS-1:0]    lt, rt;
    logic [CONTEXT_BITS-1:0] lc, rc;
    logic [TIME_BITS-1:0]    ld, rd;

    if (i == 0) begin : g_l0
      assign lv = 1'b0;
      assign lt = '0;
      assign lc = '0;
      assign ld = '0;
    end else begin : g_ln
      assign lv = c_valid[i-1];
      assign lt = c_type[i-1];
      assign lc = c_ctx[i-1];
      assign ld = c_due[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_rl
      assign rv = 1'b0;
      assign rt = '0;
      assign rc = '0;
      assign rd = '0;
    end else begin : g_rn
      assign rv = c_valid[i+1];
      assign rt = c_type[i+1];
      assign rc = c_ctx[i+1];
      assign rd = c_due[i+1];
    end

    etpq_cell #(
      .TYPE_BITS    (TYPE_BITS),
      .CONTEXT_BITS (CONTEXT_BITS),
      .IS_HEAD      (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .key_type    (key_type_r),
      .key_ctx     (key_ctx_r),
      .key_due     (key_due_r),
      .left_valid  (lv),
      .left_type   (lt),
      .left_ctx    (lc),
      .left_due    (ld),
      .right_valid (rv),
      .right_type  (rt),
      .right_ctx   (rc),
      .right_due   (rd),
      .hit_in      (hit[i]),
      .hit_out     (hit[i+1]),
      .valid       (c_valid[i]),
      .ev_type     (c_type[i]),
      .ev_ctx      (c_ctx[i]),
      .ev_due      (c_due[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          if (op_r == OP_ADVANCE) begin
            now_r <= now_r + elapsed_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_operation);
      key_type_r <= in_event_type;
      key_ctx_r  <= in_context_tag;
      key_due_r  <= now_r + in_delay;
      elapsed_r  <= in_elapsed;
    end
    if (state_r == ST_EXEC) begin
      pop_valid_r    <= (op_r == OP_POP) && c_valid[0];
      pop_type_r     <= ((op_r == OP_POP) && c_valid[0]) ? c_type[0] : '0;
      pop_ctx_r      <= ((op_r == OP_POP) && c_valid[0]) ? c_ctx[0] : '0;
      pop_due_r      <= ((op_r == OP_POP) && c_valid[0]) ? c_due[0] : '0;
      cancel_found_r <= (op_r == OP_CANCEL) && hit[QUEUE_DEPTH];
      dropped_r      <= (op_r == OP_PUSH) && full;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_popped_valid    = pop_valid_r;
  assign out_popped_type     = pop_type_r;
  assign out_popped_context  = pop_ctx_r;
  assign out_popped_due_time = pop_due_r;
  assign out_cancel_found    = cancel_found_r;
  assign out_push_dropped    = dropped_r;
  assign out_queue_empty     = !c_valid[0];
  assign out_next_due_time   = c_valid[0] ? c_due[0] : '1;
  assign out_now_time        = now_r;

endmodule
`default_nettype wire
